>>> rtl/itoa_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package itoa_pkg;

    // Widths of the item fields.
    localparam int unsigned ValueW    = 32;
    localparam int unsigned CharW     = 6;
    localparam int unsigned OutDataW  = 8;

    // Number of BCD digits needed for a 32-bit magnitude, and counter widths.
    localparam int unsigned NumDigits = 10;
    localparam int unsigned BcdW      = 4 * NumDigits;
    localparam int unsigned CntW      = $clog2(ValueW);
    localparam int unsigned IdxW      = $clog2(NumDigits);

    // Character codes.
    localparam logic [CharW-1:0] CharMinus = 6'd45;
    localparam logic [CharW-1:0] CharZero  = 6'd48;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic norm;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic idx_zero;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/itoa_ctrl.sv
// Controller state machine that sequences conversion and character output.
module itoa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  itoa_pkg::t_sts   i_sts,
    output itoa_pkg::t_cmd   o_cmd
);

    itoa_pkg::t_state r_state;
    itoa_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            itoa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = itoa_pkg::ST_CONV;
                end
            end
            itoa_pkg::ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.conv_last) begin
                    n_state = itoa_pkg::ST_NORM;
                end
            end
            itoa_pkg::ST_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = itoa_pkg::ST_SIGN;
            end
            itoa_pkg::ST_SIGN: begin
                // The datapath skips the sign for non-negative values.
                o_cmd.emit_sign = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_DIGIT: begin
                o_cmd.emit_digit = i_sts.out_free;
                if (i_sts.out_free && i_sts.idx_zero) begin
                    n_state = itoa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itoa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/itoa_dp.sv
// Datapath: magnitude, shift-and-add-3 BCD conversion and output register.
module itoa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [itoa_pkg::ValueW-1:0]         i_value,
    input  itoa_pkg::t_cmd                      i_cmd,
    output itoa_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [itoa_pkg::CharW-1:0]          o_char_code,
    output logic                                o_is_last
);

    logic                            r_neg;
    logic [itoa_pkg::ValueW-1:0]     r_bin;
    logic [itoa_pkg::BcdW-1:0]       r_bcd;
    logic [itoa_pkg::CntW-1:0]       r_cnt;
    logic [itoa_pkg::IdxW-1:0]       r_idx;
    logic                            r_out_valid;
    logic [itoa_pkg::CharW-1:0]      r_char;
    logic                            r_last;

    logic [itoa_pkg::ValueW-1:0]     mag;
    logic [itoa_pkg::BcdW-1:0]       adj;
    logic [itoa_pkg::IdxW-1:0]       top_idx;
    logic [3:0]                      cur_digit;
    logic                            emit;

    // Magnitude as an unsigned number, exact for the most negative value.
    assign mag = i_value[itoa_pkg::ValueW-1] ? (~i_value + 1'b1) : i_value;

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb begin
        for (int k = 0; k < itoa_pkg::NumDigits; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                      : r_bcd[4*k +: 4];
        end
    end

    // Position of the most significant non-zero digit; zero gives position 0.
    always_comb begin
        top_idx = '0;
        for (int k = 0; k < itoa_pkg::NumDigits; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) begin
                top_idx = itoa_pkg::IdxW'(k);
            end
        end
    end

    assign cur_digit = r_bcd[4*r_idx +: 4];

    // Conversion registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[itoa_pkg::ValueW-1];
            r_bin <= mag;
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_bcd <= {adj[itoa_pkg::BcdW-2:0], r_bin[itoa_pkg::ValueW-1]};
            r_bin <= {r_bin[itoa_pkg::ValueW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.norm) begin
            r_idx <= top_idx;
        end else if (i_cmd.emit_digit && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // Output register: a new character goes in when the old one is taken.
    assign emit = i_cmd.emit_digit || (i_cmd.emit_sign && r_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_digit) begin
            r_char <= itoa_pkg::CharZero + itoa_pkg::CharW'(cur_digit);
            r_last <= (r_idx == '0);
        end else if (i_cmd.emit_sign && r_neg) begin
            r_char <= itoa_pkg::CharMinus;
            r_last <= 1'b0;
        end
    end

    // Status and outputs.
    assign o_sts.conv_last = (r_cnt == itoa_pkg::CntW'(itoa_pkg::ValueW - 1));
    assign o_sts.idx_zero  = (r_idx == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

endmodule

>>> rtl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
//  Channel | Direction | Payload                        | Items
//  s       | in        | tdata[31:0] value (signed)     | one per number
//  m       | out       | tdata[5:0] char_code, tlast    | 1 to 11 per number
//
// A number goes through acceptance, 32 shift-and-add-3 steps, a search for the
// leading digit, a sign slot (empty for a non-negative value) and one slot per digit.
// Reset is synchronous and active low; it clears the controller and the output valid flag.
// A stalled output holds the character and pauses the sequence; the next number is
// taken while the last character still waits.
module signed_int_to_decimal_ascii_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [itoa_pkg::ValueW-1:0]         i_s_tdata,   // [31:0] value
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [itoa_pkg::OutDataW-1:0]       o_m_tdata,   // [5:0] char_code, [7:6] zero
    output logic                                o_m_tlast
);

    itoa_pkg::t_cmd              cmd;
    itoa_pkg::t_sts              sts;
    logic [itoa_pkg::CharW-1:0]  char_code;

    itoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    itoa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_char_code (char_code),
        .o_is_last   (o_m_tlast)
    );

    assign o_m_tdata = {{(itoa_pkg::OutDataW - itoa_pkg::CharW){1'b0}}, char_code};

    // A character is only written into a free output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
        else $error("character written over a waiting output item");

    // Sign and digit are never emitted in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.emit_sign && cmd.emit_digit))
        else $error("sign and digit emitted together");

    // After a number is taken the block is busy converting it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken again during conversion");

    // A minus sign never ends a run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (char_code == itoa_pkg::CharMinus)) |-> !o_m_tlast)
        else $error("minus sign marked as last character");

endmodule

>>> tb/signed_int_to_decimal_ascii_top_tb.sv
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_top_tb;

    // The run is about 220 numbers of up to 11 characters, with output stalls while idling
    // is on. This limit is many times the length of the slowest correct run.
    localparam int unsigned CycleLimit = 500000;
    localparam int unsigned DrainCycles = 60;
    localparam int unsigned NumDirected = 20;

    // One expected character of the decimal text.
    typedef struct packed {
        logic [itoa_pkg::CharW-1:0] code;
        logic                       last;
    } t_char_item;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [itoa_pkg::ValueW-1:0]   i_s_tdata = '0;     // [31:0] value
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [itoa_pkg::OutDataW-1:0] o_m_tdata;          // [5:0] char_code, [7:6] zero
    logic                          o_m_tlast;

    t_char_item  text_q[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit          idling_on = 1'b0;

    signed_int_to_decimal_ascii_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock generation.
    always #5 i_clk = ~i_clk;

    // Works out the decimal text of one value and queues its characters.
    function automatic void predict_decimal_text(input logic [itoa_pkg::ValueW-1:0] value);
        logic [itoa_pkg::ValueW-1:0] mag;
        logic [3:0]                  digs[10];
        logic                        neg;
        int                          n;
        t_char_item                  ch;
        n = 0;
        neg = value[itoa_pkg::ValueW-1];
        // The magnitude is taken as unsigned, so the most negative value needs no care.
        mag = neg ? (~value + 32'd1) : value;
        do begin
            digs[n] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n++;
        end while (mag != 0 && n < 10);
        if (neg) begin
            ch.code = itoa_pkg::CharMinus;
            ch.last = 1'b0;
            text_q.push_back(ch);
        end
        for (int k = n - 1; k >= 0; k--) begin
            ch.code = itoa_pkg::CharZero + itoa_pkg::CharW'(digs[k]);
            ch.last = (k == 0);
            text_q.push_back(ch);
        end
    endfunction

    // Offers one number on the input side, with an optional gap first, and waits for it
    // to be taken. Valid stays high afterwards so that numbers can follow back to back.
    task automatic send_value(input logic [itoa_pkg::ValueW-1:0] value);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        predict_decimal_text(value);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Picks a value with a random number of digits and a random sign, or now and then
    // a value with every bit random.
    function automatic logic [itoa_pkg::ValueW-1:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     len;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        len = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < len; i++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (len == 1) lo = 0;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag = lo + longint'($urandom) % (hi - lo + 1);
        // The most negative value lies outside the positive range, so give it a chance.
        if (len == 10 && $urandom_range(0, 7) == 0) mag = 64'sd2147483648;
        return $urandom_range(0, 1) ? itoa_pkg::ValueW'(-mag) : itoa_pkg::ValueW'(mag);
    endfunction

    // Extremes, zero, one digit and ten digit values, and the most negative value.
    task automatic test_directed_values();
        logic [itoa_pkg::ValueW-1:0] vals[NumDirected];
        vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
                 32'h5555_5555, 32'hAAAA_AAAA, -32'sd5, 32'd4294967286};
        foreach (vals[i]) send_value(vals[i]);
    endtask

    // Random values with idling on both sides.
    task automatic test_random_lengths(input int count);
        for (int i = 0; i < count; i++) send_value(pick_value());
    endtask

    // Random values at full rate: no gaps on the input and no stalls on the output.
    task automatic test_full_rate(input int count);
        idling_on = 1'b0;
        for (int i = 0; i < count; i++) send_value(pick_value());
    endtask

    // Output ready with random stalls while idling is on.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idling_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Compares each accepted character item with the oldest expected one.
    always @(posedge i_clk) begin
        t_char_item exp_ch;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (text_q.size() == 0) begin
                $error("character item with none expected: tdata %0d tlast %0d",
                       o_m_tdata, o_m_tlast);
                fail_count++;
            end else begin
                exp_ch = text_q.pop_front();
                if (o_m_tdata[itoa_pkg::CharW-1:0] !== exp_ch.code) begin
                    $error("char_code: expected %0d, actual %0d",
                           exp_ch.code, o_m_tdata[itoa_pkg::CharW-1:0]);
                    fail_count++;
                end
                if (o_m_tlast !== exp_ch.last) begin
                    $error("is_last: expected %0d, actual %0d", exp_ch.last, o_m_tlast);
                    fail_count++;
                end
                if (o_m_tdata[itoa_pkg::OutDataW-1:itoa_pkg::CharW] !== '0) begin
                    $error("tdata padding: expected 0, actual %0d",
                           o_m_tdata[itoa_pkg::OutDataW-1:itoa_pkg::CharW]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if it goes on far too long.
    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Main sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idling_on = 1'b1;
        test_directed_values();
        test_random_lengths(150);
        test_full_rate(50);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Let the last characters come out, then keep watching for stray items.
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
